// ===== hdl/mitbt_pkg.sv =====
// Package for the 2x2 mutual information block: widths, constants and sequencer states.
// Depends on nothing; used by mitbt_datapath and mutual_information_two_by_two.
package mitbt_pkg;
   localparam int COUNT_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 40;
   localparam int MAX_TERMS_DEF  = 1024;
   localparam int TOL_BITS       = 32;
   localparam int OUT_BITS       = 32;
   localparam logic [61:0] LN2_Q62 = 62'd3196577161300662488;
   localparam logic [TOL_BITS-1:0] TOL_RESET = 32'd4096;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CELL, ST_MUL_A, ST_MUL_B, ST_ZDIV_GO, ST_ZDIV, ST_Z2,
      ST_TEST, ST_PMUL, ST_TDIV_GO, ST_TDIV, ST_LDIV_GO, ST_LDIV, ST_MMUL,
      ST_MDIV_GO, ST_MDIV, ST_ACC, ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
   } div_ctrl_type;
endpackage

// ===== hdl/mitbt_datapath.sv =====
// Shared restoring divider, one quotient bit per cycle, for the mutual information block.
// Depends on mitbt_pkg (div_ctrl_type).
module mitbt_datapath #(
   parameter int NUM_BITS = 128,
   parameter int Q_BITS   = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [NUM_BITS-1:0]    num,
   input  logic [NUM_BITS-1:0]    den,
   output logic [Q_BITS-1:0]      quot,
   output mitbt_pkg::div_ctrl_type ctrl
);
   import mitbt_pkg::*;
   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] rem_ff, num_ff, den_ff;
   logic [Q_BITS-1:0]   q_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic                busy_ff;
   logic [NUM_BITS:0]   shifted, trial;

   assign shifted = {rem_ff, num_ff[NUM_BITS-1]};
   assign trial   = shifted - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_BITS'(NUM_BITS);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         num_ff <= num;
         den_ff <= den;
         q_ff   <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[NUM_BITS-2:0], 1'b0};
         if (!trial[NUM_BITS] && den_ff != '0) begin
            rem_ff <= trial[NUM_BITS-1:0];
            q_ff   <= {q_ff[Q_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[NUM_BITS-1:0];
            q_ff   <= {q_ff[Q_BITS-2:0], 1'b0};
         end
      end
   end

   assign quot       = q_ff;
   assign ctrl.start = start;
   assign ctrl.busy  = busy_ff;
endmodule

// ===== hdl/mutual_information_two_by_two.sv =====
// Top level of the 2x2 mutual information block: sequencer, shared multiplier and divider.
// Depends on mitbt_pkg and mitbt_datapath.
//
// One request takes the four counts and returns one result. The four cells are
// worked one after the other. Every division (z, each series term, the ln2
// scaling and the cell weighting) runs on one shared 128-step restoring
// divider. Every product comes from one 32x32 multiplier that sums four
// partial products. A zero cell skips the multiplies and divisions, and an
// all-zero table skips the cells. The block is not ready while a request is in
// progress; a finished result waits in the output register and the next
// request is taken alongside it.
module mutual_information_two_by_two #(
   parameter int COUNT_BITS = mitbt_pkg::COUNT_BITS_DEF,
   parameter int FRAC_BITS  = mitbt_pkg::FRAC_BITS_DEF,
   parameter int MAX_TERMS  = mitbt_pkg::MAX_TERMS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [15:0]                     req_count_11,
   input  logic [15:0]                     req_count_10,
   input  logic [15:0]                     req_count_01,
   input  logic [15:0]                     req_count_00,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [mitbt_pkg::OUT_BITS-1:0] rsp_mutual_info,
   output logic                            rsp_empty_table,
   output logic                            rsp_not_converged,
   input  logic                            csr_write_enable,
   input  logic [mitbt_pkg::TOL_BITS-1:0]  csr_write_data
);
   import mitbt_pkg::*;

   localparam int TB   = COUNT_BITS + 2;
   localparam int TERM_BITS = $clog2(MAX_TERMS + 1);
   localparam int DIVB = 2 * TERM_BITS + 2;

   logic [TOL_BITS-1:0] tol_ff;
   state_type state_ff, state_in;

   logic [COUNT_BITS-1:0] n_ff [4];
   logic [TB-1:0] total_ff, r_ff, c_ff, n_cur;
   logic [1:0]   cell_ff;
   logic [127:0] a_ff;
   logic [63:0]  z_ff, z2_ff, pw_ff, acc_ff, lg_ff;
   logic [127:0] mul_ff;
   logic [DIVB-1:0] div_ff;
   logic [TERM_BITS-1:0] terms_ff;
   logic         neg_ff, flag_ff;
   logic signed [39:0] sum_ff;
   logic [63:0]  tol_q;

   logic [63:0]  mul_x, mul_y;
   logic [1:0]   mstep_ff;
   logic         mul_run, mul_last;
   logic [31:0]  mul_xs, mul_ys;
   logic [63:0]  mul_prod;
   logic [127:0] mul_pp;
   logic [63:0]  mul_frac;
   logic         div_start;
   logic [127:0] div_num, div_den;
   logic [63:0]  div_q;
   div_ctrl_type div_ctrl;

   logic                         rsp_valid_ff;
   logic signed [OUT_BITS-1:0]   mi_ff;
   logic                         empty_ff, nc_ff;

   mitbt_datapath #(.NUM_BITS(128), .Q_BITS(64)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(div_num), .den(div_den), .quot(div_q), .ctrl(div_ctrl));

   always_comb begin
      if (FRAC_BITS >= 32) tol_q = 64'(tol_ff) << (FRAC_BITS - 32);
      else                 tol_q = 64'(tol_ff) >> (32 - FRAC_BITS);
   end

   always_comb begin
      case (cell_ff)
         2'd0:    n_cur = TB'(n_ff[0]);
         2'd1:    n_cur = TB'(n_ff[1]);
         2'd2:    n_cur = TB'(n_ff[2]);
         default: n_cur = TB'(n_ff[3]);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) tol_ff <= TOL_RESET;
      else if (csr_write_enable) tol_ff <= csr_write_data;
   end

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         ST_MUL_A: begin mul_x = 64'(n_cur); mul_y = 64'(total_ff); end
         ST_MUL_B: begin mul_x = 64'(r_ff);  mul_y = 64'(c_ff);     end
         ST_Z2:    begin mul_x = z_ff;       mul_y = z_ff;          end
         ST_PMUL:  begin mul_x = pw_ff;      mul_y = z2_ff;         end
         ST_MMUL:  begin mul_x = 64'(n_cur); mul_y = lg_ff;         end
         default:  begin mul_x = '0;         mul_y = '0;            end
      endcase
   end

   // four 32x32 partial products, one a cycle, summed into the product register
   always_comb begin
      mul_run  = (state_ff == ST_MUL_A) || (state_ff == ST_MUL_B) || (state_ff == ST_Z2)
              || (state_ff == ST_PMUL) || (state_ff == ST_MMUL);
      mul_last = mul_run && (mstep_ff == 2'd3);
      mul_xs   = mstep_ff[1] ? mul_x[63:32] : mul_x[31:0];
      mul_ys   = mstep_ff[0] ? mul_y[63:32] : mul_y[31:0];
      mul_prod = 64'(mul_xs) * 64'(mul_ys);
      case (mstep_ff)
         2'd0:    mul_pp = 128'(mul_prod);
         2'd3:    mul_pp = {mul_prod, 64'd0};
         default: mul_pp = {32'd0, mul_prod, 32'd0};
      endcase
   end

   assign mul_frac = 64'(mul_ff >> FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) mstep_ff <= '0;
      else if (mul_run) mstep_ff <= mstep_ff + 1'b1;
   end

   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      case (state_ff)
         ST_ZDIV_GO: begin
            div_start = 1'b1;
            div_num = ((a_ff < mul_ff) ? mul_ff - a_ff : a_ff - mul_ff) << FRAC_BITS;
            div_den = a_ff + mul_ff;
         end
         ST_TDIV_GO: begin
            div_start = 1'b1;
            div_num = 128'(mul_frac);
            div_den = 128'(div_ff + DIVB'(2));
         end
         ST_LDIV_GO: begin
            div_start = 1'b1;
            div_num = 128'({acc_ff[62:0], 1'b0}) << 62;
            div_den = 128'(LN2_Q62);
         end
         ST_MDIV_GO: begin
            div_start = 1'b1;
            if (FRAC_BITS >= 30) begin
               div_num = mul_ff;
               div_den = 128'(total_ff) << (FRAC_BITS - 30);
            end else begin
               div_num = mul_ff << (30 - FRAC_BITS);
               div_den = 128'(total_ff);
            end
         end
         default: ;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid && req_ready) state_in = ST_CELL;
         ST_CELL:  state_in = (total_ff == '0) ? ST_DONE
                            : (n_cur == '0) ? ST_ACC : ST_MUL_A;
         ST_MUL_A: if (mul_last) state_in = ST_MUL_B;
         ST_MUL_B: if (mul_last) state_in = ST_ZDIV_GO;
         ST_ZDIV_GO: state_in = ST_ZDIV;
         ST_ZDIV:  if (!div_ctrl.busy) state_in = ST_Z2;
         ST_Z2:    if (mul_last) state_in = ST_TEST;
         ST_TEST:  if (pw_ff > tol_q && terms_ff < TERM_BITS'(MAX_TERMS)) state_in = ST_PMUL;
                   else state_in = ST_LDIV_GO;
         ST_PMUL:  if (mul_last) state_in = ST_TDIV_GO;
         ST_TDIV_GO: state_in = ST_TDIV;
         ST_TDIV:  if (!div_ctrl.busy) state_in = ST_TEST;
         ST_LDIV_GO: state_in = ST_LDIV;
         ST_LDIV:  if (!div_ctrl.busy) state_in = ST_MMUL;
         ST_MMUL:  if (mul_last) state_in = ST_MDIV_GO;
         ST_MDIV_GO: state_in = ST_MDIV;
         ST_MDIV:  if (!div_ctrl.busy) state_in = ST_ACC;
         ST_ACC:   state_in = (cell_ff == 2'd3) ? ST_DONE : ST_CELL;
         ST_DONE:  if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (mul_run) mul_ff <= (mstep_ff == 2'd0) ? mul_pp : mul_ff + mul_pp;
      case (state_ff)
         ST_IDLE: if (req_valid && req_ready) begin
            n_ff[0]  <= COUNT_BITS'(req_count_11);
            n_ff[1]  <= COUNT_BITS'(req_count_10);
            n_ff[2]  <= COUNT_BITS'(req_count_01);
            n_ff[3]  <= COUNT_BITS'(req_count_00);
            total_ff <= TB'(COUNT_BITS'(req_count_11)) + TB'(COUNT_BITS'(req_count_10))
                      + TB'(COUNT_BITS'(req_count_01)) + TB'(COUNT_BITS'(req_count_00));
            cell_ff  <= 2'd0;
            sum_ff   <= '0;
            flag_ff  <= 1'b0;
         end
         ST_CELL: begin
            r_ff <= cell_ff[1] ? TB'(n_ff[2]) + TB'(n_ff[3]) : TB'(n_ff[0]) + TB'(n_ff[1]);
            c_ff <= cell_ff[0] ? TB'(n_ff[1]) + TB'(n_ff[3]) : TB'(n_ff[0]) + TB'(n_ff[2]);
            lg_ff <= '0;
         end
         // n*N is complete only until the first partial product of r*c lands
         ST_MUL_B: if (mstep_ff == 2'd0) a_ff <= mul_ff;
         ST_ZDIV_GO: neg_ff <= a_ff < mul_ff;
         ST_ZDIV: if (!div_ctrl.busy) begin
            z_ff <= div_q; pw_ff <= div_q; acc_ff <= div_q;
            div_ff <= DIVB'(1); terms_ff <= TERM_BITS'(1);
         end
         ST_TEST: begin
            // first visit: the product register still holds z*z
            if (terms_ff == TERM_BITS'(1)) z2_ff <= mul_frac;
            if (pw_ff > tol_q && terms_ff >= TERM_BITS'(MAX_TERMS)) flag_ff <= 1'b1;
         end
         ST_TDIV_GO: begin
            pw_ff  <= mul_frac;
            div_ff <= div_ff + DIVB'(2);
         end
         ST_TDIV: if (!div_ctrl.busy) begin
            acc_ff   <= acc_ff + div_q;
            terms_ff <= terms_ff + 1'b1;
         end
         ST_LDIV: if (!div_ctrl.busy) lg_ff <= div_q;
         ST_ACC: begin
            if (n_cur != '0)
               sum_ff <= neg_ff ? sum_ff - 40'(signed'({1'b0, div_q[38:0]}))
                                : sum_ff + 40'(signed'({1'b0, div_q[38:0]}));
            cell_ff <= cell_ff + 1'b1;
         end
         default: ;
      endcase
   end

   // output register
   logic signed [OUT_BITS-1:0] sat;
   always_comb begin
      if (sum_ff > 40'sd2147483647)       sat = 32'sh7fffffff;
      else if (sum_ff < -40'sd2147483648) sat = 32'sh80000000;
      else                                sat = sum_ff[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) begin
         mi_ff    <= (total_ff == '0) ? '0 : sat;
         empty_ff <= total_ff == '0;
         nc_ff    <= (total_ff == '0) ? 1'b0 : flag_ff;
      end
   end

   assign req_ready         = state_ff == ST_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mutual_info   = mi_ff;
   assign rsp_empty_table   = empty_ff;
   assign rsp_not_converged = nc_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mutual_info))
      else $error("result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      div_ctrl.start |-> !div_ctrl.busy)
      else $error("divider restarted while busy");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_table |-> rsp_mutual_info == 0 && !rsp_not_converged)
      else $error("empty table gave non-zero result");
endmodule

// ===== test/tb_mutual_information_two_by_two.sv =====
// Testbench for mutual_information_two_by_two: directed tables, then random tables under
// several tolerance settings, each result checked against a local model or a given value.
// Depends on mitbt_pkg and the RTL of the block.
module tb_mutual_information_two_by_two;
   timeunit 1ns;
   timeprecision 1ps;
   import mitbt_pkg::*;

   localparam int FRAC = FRAC_BITS_DEF;
   localparam int WATCHDOG_LIMIT = 2000000;

   typedef struct {
      logic [15:0] c11, c10, c01, c00;
   } table_type;

   typedef struct {
      logic signed [OUT_BITS-1:0] info;
      logic empty;
      logic stalled;
   } mi_type;

   typedef struct {
      logic [15:0] c11, c10, c01, c00;
      bit          typed;
      mi_type      res;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [15:0] req_count_11 = 0, req_count_10 = 0, req_count_01 = 0, req_count_00 = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [OUT_BITS-1:0] rsp_mutual_info;
   logic rsp_empty_table, rsp_not_converged;
   logic csr_write_enable = 0;
   logic [TOL_BITS-1:0] csr_write_data = 0;

   mi_type pending_mi[$];
   logic [TOL_BITS-1:0] tol_shadow = TOL_RESET;
   int errors = 0;
   int quiet_cycles = 0;
   bit calm = 0;

   mutual_information_two_by_two dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_count_11(req_count_11), .req_count_10(req_count_10),
      .req_count_01(req_count_01), .req_count_00(req_count_00),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_mutual_info(rsp_mutual_info), .rsp_empty_table(rsp_empty_table),
      .rsp_not_converged(rsp_not_converged),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // One cell's signed contribution in Q.30; sets stalled when the term cap is hit.
   function automatic longint cell_info(logic [63:0] n, logic [63:0] r, logic [63:0] c,
                                        logic [63:0] total, logic [63:0] tol,
                                        inout logic stalled);
      logic [127:0] a, b, diff, den, num;
      logic [63:0] z, z2, pw, acc, dv, lg, mag, twice;
      int terms;
      bit neg;
      if (n == 0) return 0;
      a = 128'(n) * 128'(total);
      b = 128'(r) * 128'(c);
      neg = a < b;
      diff = neg ? b - a : a - b;
      den = a + b;
      z = 64'((diff << FRAC) / den);
      z2 = 64'((128'(z) * 128'(z)) >> FRAC);
      pw = z;
      acc = z;
      dv = 1;
      terms = 1;
      while (pw > tol) begin
         if (terms >= MAX_TERMS_DEF) begin
            stalled = 1;
            break;
         end
         pw = 64'((128'(pw) * 128'(z2)) >> FRAC);
         dv += 2;
         acc += pw / dv;
         terms++;
      end
      twice = acc << 1;
      num = 128'(twice) << 62;
      lg = 64'(num / 128'(LN2_Q62));
      mag = 64'((128'(n) * 128'(lg)) / 128'(total << (FRAC - 30)));
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic mi_type mutual_info_of(table_type t, logic [TOL_BITS-1:0] tol_q32);
      mi_type m;
      logic [63:0] n11, n10, n01, n00, total, tol;
      longint sum;
      logic stalled;
      n11 = t.c11; n10 = t.c10; n01 = t.c01; n00 = t.c00;
      total = n11 + n10 + n01 + n00;
      m.info = 0; m.empty = 0; m.stalled = 0;
      if (total == 0) begin
         m.empty = 1;
         return m;
      end
      tol = 64'(tol_q32) << (FRAC - 32);
      stalled = 0;
      sum = cell_info(n11, n11 + n10, n11 + n01, total, tol, stalled)
          + cell_info(n10, n11 + n10, n10 + n00, total, tol, stalled)
          + cell_info(n01, n01 + n00, n11 + n01, total, tol, stalled)
          + cell_info(n00, n01 + n00, n10 + n00, total, tol, stalled);
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      m.info = sum[31:0];
      m.stalled = stalled;
      return m;
   endfunction

   // Present one request and hold it until taken; idle at random before it.
   task automatic send_table(table_type t, bit typed, mi_type lit);
      while (!calm && $urandom_range(99) < 28) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_count_11 <= t.c11;
      req_count_10 <= t.c10;
      req_count_01 <= t.c01;
      req_count_00 <= t.c00;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_mi.push_back(typed ? lit : mutual_info_of(t, tol_shadow));
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_mi.size() != 0) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [TOL_BITS-1:0] value);
      drain();
      csr_write_enable <= 1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 0;
      tol_shadow = value;
   endtask

   function automatic logic [15:0] random_count(int mode);
      case (mode)
         0: begin
            return ($urandom_range(15) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
         end
         1: begin
            return 16'($urandom_range(0, 255));
         end
         default: begin
            return 16'($urandom_range(16384, 65535));
         end
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         rsp_ready <= calm || ($urandom_range(99) >= 28);
         if (rsp_valid && rsp_ready) begin
            if (pending_mi.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_mutual_info);
               errors++;
            end else begin
               mi_type e;
               e = pending_mi.pop_front();
               if (e.info !== rsp_mutual_info) begin
                  $display("%0t: mutual_info expected %h got %h", $time, e.info,
                           rsp_mutual_info);
                  errors++;
               end
               if (e.empty !== rsp_empty_table) begin
                  $display("%0t: empty_table expected %b got %b", $time, e.empty,
                           rsp_empty_table);
                  errors++;
               end
               if (e.stalled !== rsp_not_converged) begin
                  $display("%0t: not_converged expected %b got %b", $time, e.stalled,
                           rsp_not_converged);
                  errors++;
               end
            end
         end
      end
   end

   // Abort when neither channel moves for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_mutual_information_two_by_two: errors");
            $finish;
         end
      end
   end

   initial begin
      row_type directed[$];
      logic [TOL_BITS-1:0] phase_tol[6];
      int phase_modes[6];
      table_type t;
      mi_type zero_mi;
      int mode;

      zero_mi.info = 0; zero_mi.empty = 0; zero_mi.stalled = 0;
      directed = '{
         '{16'd0, 16'd0, 16'd0, 16'd0, 1, '{32'sd0, 1'b1, 1'b0}},
         '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, '{32'sd0, 1'b0, 1'b0}},
         '{16'd5, 16'd0, 16'd0, 16'd0, 1, '{32'sd0, 1'b0, 1'b0}},
         '{16'd0, 16'd0, 16'd0, 16'hFFFF, 1, '{32'sd0, 1'b0, 1'b0}},
         '{16'd3, 16'd3, 16'd7, 16'd7, 1, '{32'sd0, 1'b0, 1'b0}},
         '{16'd1, 16'd0, 16'd0, 16'd1, 0, zero_mi},
         '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 0, zero_mi},
         '{16'd9, 16'd1, 16'd2, 16'd8, 0, zero_mi},
         '{16'd1, 16'd2, 16'd3, 16'd4, 0, zero_mi},
         '{16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 0, zero_mi},
         '{16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE, 0, zero_mi},
         '{16'd1, 16'hFFFF, 16'hFFFF, 16'd0, 0, zero_mi},
         '{16'd100, 16'd0, 16'd50, 16'd25, 0, zero_mi}
      };
      phase_tol = '{32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, 32'h0100_0000,
                    32'h0010_0000, TOL_RESET};
      // Bit per allowed count mode: small, byte, wide.
      phase_modes = '{7, 1, 1, 7, 5, 5};

      repeat (4) @(posedge clock);
      reset <= 0;

      foreach (directed[i]) begin
         t.c11 = directed[i].c11; t.c10 = directed[i].c10;
         t.c01 = directed[i].c01; t.c00 = directed[i].c00;
         send_table(t, directed[i].typed, directed[i].res);
      end

      foreach (phase_tol[p]) begin
         write_tolerance(phase_tol[p]);
         calm = (p == 4);
         repeat (15) begin
            do mode = $urandom_range(0, 2); while (!phase_modes[p][mode]);
            t.c11 = random_count(mode); t.c10 = random_count(mode);
            t.c01 = random_count(mode); t.c00 = random_count(mode);
            send_table(t, 0, zero_mi);
         end
      end

      drain();
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("tb_mutual_information_two_by_two: clean");
      end else begin
         $display("tb_mutual_information_two_by_two: errors");
      end
      $finish;
   end
endmodule

// ===== files.f =====
hdl/mitbt_pkg.sv
hdl/mitbt_datapath.sv
hdl/mutual_information_two_by_two.sv
test/tb_mutual_information_two_by_two.sv
